// File: sv/qpc_pkg.sv
// Package: beat types, request codes and command and status types of the pulse counter.
`default_nettype none

package qpc_pkg;

	localparam int NUM_SLOTS    = 4;
	localparam int BACKUP_BYTES = 16;
	localparam int RES_WIDTH    = 32;

	localparam logic [1:0] REQ_SAMPLE  = 2'd0;
	localparam logic [1:0] REQ_RESTORE = 2'd1;
	localparam logic [1:0] REQ_SAVE    = 2'd2;

	localparam logic [3:0] BYTE_SWIZZLE = 4'hC;
	localparam logic [3:0] LAST_POS     = 4'hF;
	localparam logic [4:0] LEVELS_IDLE  = 5'h1F;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] channel_levels;
		logic       button_level;
		logic [3:0] restore_index;
		logic [7:0] restore_data;
		logic       restore_last;
	} in_beat_t;

	typedef struct packed {
		logic                 save_valid;
		logic [3:0]           save_addr;
		logic [7:0]           save_byte;
		logic                 last;
		logic [3:0]           counted_mask;
		logic                 cleared;
		logic                 dirty_flag;
		logic [RES_WIDTH-1:0] count_ch0;
		logic [RES_WIDTH-1:0] count_ch1;
		logic [RES_WIDTH-1:0] count_ch2;
		logic [RES_WIDTH-1:0] count_ch3;
	} out_beat_t;

	typedef struct packed {
		logic       take_item;
		logic       load_result;
		logic       save_beat;
		logic [3:0] save_pos;
	} cmd_t;

	typedef struct packed {
		logic save_dirty;
	} status_t;

endpackage

`default_nettype wire

// File: sv/qpc_ctrl.sv
// Controller: input handshake, save sequencing and the output valid flag.
`default_nettype none

module qpc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire qpc_pkg::status_t status,
	output qpc_pkg::cmd_t        cmd
);
	import qpc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SAVE = 2'b10
	} state_t;

	state_t     state_q;
	logic [3:0] pos_q;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready          = out_free;
				cmd.take_item     = accept;
				cmd.load_result   = accept;
				cmd.save_beat     = accept && status.save_dirty;
				cmd.save_pos      = '0;
			end
			ST_SAVE: begin
				cmd.load_result = out_free;
				cmd.save_beat   = out_free;
				cmd.save_pos    = pos_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && status.save_dirty) begin
						state_q <= ST_SAVE;
						pos_q   <= 4'd1;
					end
				end
				ST_SAVE: begin
					if (out_free) begin
						pos_q <= pos_q + 4'd1;
						if (pos_q == LAST_POS) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/qpc_datapath.sv
// Datapath: level history, pulse counters, dirty flag and the result register.
`default_nettype none

module qpc_datapath #(
	parameter int NUM_CHANNELS = 4,
	parameter int COUNT_WIDTH  = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire qpc_pkg::in_beat_t in_data,
	input  wire qpc_pkg::cmd_t     cmd,
	output qpc_pkg::status_t       status,
	output qpc_pkg::out_beat_t     out_data
);
	import qpc_pkg::*;

	logic [4:0]             prev_q;
	logic [COUNT_WIDTH-1:0] cnt_q [NUM_SLOTS];
	logic                   dirty_q;
	out_beat_t              res_q;

	logic [4:0]             prev_d;
	logic [COUNT_WIDTH-1:0] cnt_d [NUM_SLOTS];
	logic                   dirty_d;
	logic [3:0]             en;
	logic [3:0]             lv;
	logic [4:0]             now_lv;
	logic [4:0]             prev_m;
	logic [3:0]             counted;
	logic                   clr;
	logic [3:0]             rb;
	logic [31:0]            wide;
	logic [3:0]             sb;
	logic [31:0]            wsel;
	logic [7:0]             sbyte;
	out_beat_t              res_d;

	assign status.save_dirty = (in_data.req_type == REQ_SAVE) && dirty_q;

	always_comb begin
		for (int n = 0; n < NUM_SLOTS; n++) begin
			en[n] = (n < NUM_CHANNELS);
		end
	end

	always_comb begin
		prev_d  = prev_q;
		cnt_d   = cnt_q;
		dirty_d = dirty_q;
		counted = '0;
		clr     = 1'b0;
		lv      = in_data.channel_levels & en;
		now_lv  = {in_data.button_level, lv};
		prev_m  = prev_q & {1'b1, en};
		rb      = in_data.restore_index ^ BYTE_SWIZZLE;
		wide    = '0;
		if (cmd.take_item) begin
			case (in_data.req_type)
				REQ_SAMPLE: begin
					counted = prev_m[3:0] & ~lv & en;
					clr     = prev_m[4] && !in_data.button_level;
					for (int n = 0; n < NUM_SLOTS; n++) begin
						if (clr) begin
							cnt_d[n] = '0;
						end else if (counted[n]) begin
							cnt_d[n] = cnt_q[n] + COUNT_WIDTH'(1);
						end
					end
					if (now_lv != prev_m) begin
						dirty_d = 1'b1;
					end
					prev_d = now_lv;
				end
				REQ_RESTORE: begin
					for (int n = 0; n < NUM_SLOTS; n++) begin
						if (rb[3:2] == 2'(n)) begin
							wide = 32'(cnt_q[n]);
							wide[{rb[1:0], 3'b000} +: 8] = in_data.restore_data;
							cnt_d[n] = wide[COUNT_WIDTH-1:0];
						end
					end
					if (in_data.restore_last) begin
						dirty_d = 1'b0;
						for (int n = 0; n < NUM_SLOTS; n++) begin
							if (cnt_d[n] == '1) begin
								cnt_d[n] = '0;
								dirty_d  = 1'b1;
							end
						end
					end
				end
				REQ_SAVE: begin
					dirty_d = 1'b0;
				end
				default: begin
					dirty_d = dirty_q;
				end
			endcase
		end
	end

	always_comb begin
		sb    = cmd.save_pos ^ BYTE_SWIZZLE;
		wsel  = 32'(cnt_d[sb[3:2]]);
		sbyte = wsel[{sb[1:0], 3'b000} +: 8];
		res_d.save_valid   = cmd.save_beat;
		res_d.save_addr    = cmd.save_beat ? cmd.save_pos : 4'd0;
		res_d.save_byte    = cmd.save_beat ? sbyte : 8'd0;
		res_d.last         = cmd.save_beat ? (cmd.save_pos == LAST_POS) : 1'b1;
		res_d.counted_mask = counted;
		res_d.cleared      = clr;
		res_d.dirty_flag   = dirty_d;
		res_d.count_ch0    = RES_WIDTH'(cnt_d[0]);
		res_d.count_ch1    = RES_WIDTH'(cnt_d[1]);
		res_d.count_ch2    = RES_WIDTH'(cnt_d[2]);
		res_d.count_ch3    = RES_WIDTH'(cnt_d[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= LEVELS_IDLE;
			dirty_q <= 1'b0;
			for (int n = 0; n < NUM_SLOTS; n++) begin
				cnt_q[n] <= '0;
			end
		end else if (cmd.take_item) begin
			prev_q  <= prev_d;
			dirty_q <= dirty_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_q <= res_d;
		end
	end

	assign out_data = res_q;

endmodule

`default_nettype wire

// File: sv/quad_pulse_counter_with_backup_unit.sv
// Top level of the four-channel pulse counter with power-fail backup.
//
//   Channel   Direction   Beat type    Handshake
//   in        input       in_beat_t    in_valid / in_ready
//   out       output      out_beat_t   out_valid / out_ready
//
// A sample, restore or clean save gives one result beat.
// A dirty save gives 16 beats, one per cycle while out_ready stays high; no
// input beat is taken until the last of them is loaded into the output register.
// A new input beat is taken in the cycle in which the held result leaves; while
// out_ready is low with a result held, in_ready stays low.
// Reset clears the counters and dirty flag and sets the level history high.
`default_nettype none

module quad_pulse_counter_with_backup_unit #(
	parameter int NUM_CHANNELS = 4,
	parameter int COUNT_WIDTH  = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire qpc_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output qpc_pkg::out_beat_t      out_data
);
	import qpc_pkg::*;

	cmd_t    cmd;
	status_t status;

	qpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	qpc_datapath #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Testbench of the four-channel pulse counter with power-fail backup: directed and random beats.
`timescale 1ns / 100ps

module testbench;
	import qpc_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_data;

	logic [4:0]           level_hist;
	logic [RES_WIDTH-1:0] pulse_cnt [NUM_SLOTS];
	logic                 dirty;
	out_beat_t            expected_beats [$];
	int                   mismatches = 0;
	bit                   quiet = 1'b0;
	bit                   hold_request = 1'b0;

	quad_pulse_counter_with_backup_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("[quad_pulse_counter_with_backup_unit] ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic out_beat_t with_state(out_beat_t r);
		r.dirty_flag = dirty;
		r.count_ch0  = pulse_cnt[0];
		r.count_ch1  = pulse_cnt[1];
		r.count_ch2  = pulse_cnt[2];
		r.count_ch3  = pulse_cnt[3];
		return r;
	endfunction

	task automatic predict_results(input in_beat_t b);
		out_beat_t  r;
		logic [4:0] now_lv;
		logic [3:0] hits;
		logic       clr;
		logic [3:0] bidx;
		logic [7:0] image [BACKUP_BYTES];
		r = '0;
		r.last = 1'b1;
		case (b.req_type)
			REQ_SAMPLE: begin
				now_lv = {b.button_level, b.channel_levels};
				hits = level_hist[3:0] & ~b.channel_levels;
				clr = level_hist[4] & ~b.button_level;
				for (int n = 0; n < NUM_SLOTS; n++)
					if (hits[n])
						pulse_cnt[n] = pulse_cnt[n] + 1'b1;
				if (clr)
					for (int n = 0; n < NUM_SLOTS; n++)
						pulse_cnt[n] = '0;
				if (now_lv != level_hist)
					dirty = 1'b1;
				level_hist = now_lv;
				r.counted_mask = hits;
				r.cleared = clr;
				expected_beats.push_back(with_state(r));
			end
			REQ_RESTORE: begin
				bidx = b.restore_index ^ BYTE_SWIZZLE;
				pulse_cnt[bidx[3:2]][{bidx[1:0], 3'b000} +: 8] = b.restore_data;
				if (b.restore_last) begin
					dirty = 1'b0;
					for (int n = 0; n < NUM_SLOTS; n++)
						if (&pulse_cnt[n]) begin
							pulse_cnt[n] = '0;
							dirty = 1'b1;
						end
				end
				expected_beats.push_back(with_state(r));
			end
			REQ_SAVE: begin
				if (dirty) begin
					for (int p = 0; p < BACKUP_BYTES; p++) begin
						bidx = 4'(p) ^ BYTE_SWIZZLE;
						image[p] = pulse_cnt[bidx[3:2]][{bidx[1:0], 3'b000} +: 8];
					end
					dirty = 1'b0;
					for (int p = 0; p < BACKUP_BYTES; p++) begin
						r.save_valid = 1'b1;
						r.save_addr = 4'(p);
						r.save_byte = image[p];
						r.last = (4'(p) == LAST_POS);
						expected_beats.push_back(with_state(r));
					end
				end else begin
					expected_beats.push_back(with_state(r));
				end
			end
			default: expected_beats.push_back(with_state(r));
		endcase
	endtask

	task automatic send_request(input in_beat_t b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		predict_results(b);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_beats.size() != 0);
	endtask

	function automatic in_beat_t noisy_beat(logic [1:0] req);
		in_beat_t b;
		b = in_beat_t'($urandom);
		b.req_type = req;
		return b;
	endfunction

	function automatic in_beat_t sample_beat(logic [3:0] lv, logic btn);
		in_beat_t b;
		b = noisy_beat(REQ_SAMPLE);
		b.channel_levels = lv;
		b.button_level = btn;
		return b;
	endfunction

	function automatic in_beat_t restore_beat(logic [3:0] pos, logic [7:0] data, logic fin);
		in_beat_t b;
		b = noisy_beat(REQ_RESTORE);
		b.restore_index = pos;
		b.restore_data = data;
		b.restore_last = fin;
		return b;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				report_mismatch("unexpected beat", out_data.count_ch0, '0);
			end else begin
				want = expected_beats.pop_front();
				check_field("save_valid", out_data.save_valid, want.save_valid);
				check_field("save_addr", out_data.save_addr, want.save_addr);
				check_field("save_byte", out_data.save_byte, want.save_byte);
				check_field("last", out_data.last, want.last);
				check_field("counted_mask", out_data.counted_mask, want.counted_mask);
				check_field("cleared", out_data.cleared, want.cleared);
				check_field("dirty_flag", out_data.dirty_flag, want.dirty_flag);
				check_field("count_ch0", out_data.count_ch0, want.count_ch0);
				check_field("count_ch1", out_data.count_ch1, want.count_ch1);
				check_field("count_ch2", out_data.count_ch2, want.count_ch2);
				check_field("count_ch3", out_data.count_ch3, want.count_ch3);
			end
		end
	end

	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				stall_left = pick_gap();
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic test_directed();
		send_request(noisy_beat(REQ_SAVE));
		send_request(in_beat_t'({REQ_UNUSED, 18'h3FFFF}));
		send_request(sample_beat(4'hF, 1'b1));
		send_request(sample_beat(4'h0, 1'b0));
		send_request(sample_beat(4'hF, 1'b1));
		send_request(sample_beat(4'hA, 1'b1));
		send_request(noisy_beat(REQ_SAVE));
		send_request(noisy_beat(REQ_SAVE));
		for (int p = 8; p < 12; p++)
			send_request(restore_beat(4'(p), 8'hFF, p == 11));
		send_request(restore_beat(4'h0, 8'hFE, 1'b0));
		send_request(restore_beat(4'h1, 8'hFF, 1'b0));
		send_request(restore_beat(4'h2, 8'hFF, 1'b0));
		send_request(restore_beat(4'h3, 8'hFF, 1'b1));
		send_request(sample_beat(4'hF, 1'b1));
		send_request(sample_beat(4'h7, 1'b1));
		send_request(sample_beat(4'hF, 1'b1));
		send_request(sample_beat(4'h7, 1'b1));
		send_request(restore_beat(4'h5, 8'h00, 1'b0));
		send_request(noisy_beat(REQ_SAVE));
	endtask

	task automatic send_restore_image();
		logic [RES_WIDTH-1:0] words [NUM_SLOTS];
		logic [3:0]           bidx;
		for (int n = 0; n < NUM_SLOTS; n++)
			case ($urandom_range(0, 3))
				0: words[n] = '1;
				1: words[n] = 32'hFFFF_FFFF - $urandom_range(1, 3);
				default: words[n] = $urandom;
			endcase
		for (int p = 0; p < BACKUP_BYTES; p++) begin
			bidx = 4'(p) ^ BYTE_SWIZZLE;
			send_request(restore_beat(4'(p), words[bidx[3:2]][{bidx[1:0], 3'b000} +: 8],
				4'(p) == LAST_POS));
		end
	endtask

	task automatic send_random_beat();
		int         r;
		int         idx;
		logic [3:0] lv;
		logic       btn;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			lv = level_hist[3:0];
			idx = $urandom_range(0, 3);
			if ($urandom_range(0, 3) == 0)
				lv = 4'($urandom);
			else
				lv[idx] = ~lv[idx];
			btn = level_hist[4];
			if ($urandom_range(0, 9) == 0)
				btn = ~btn;
			send_request(sample_beat(lv, btn));
		end else if (r < 88) begin
			send_request(noisy_beat(REQ_SAVE));
		end else if (r < 95) begin
			send_request(noisy_beat(REQ_RESTORE));
		end else begin
			send_request(noisy_beat(REQ_UNUSED));
		end
	endtask

	task automatic test_random_traffic();
		int sent;
		sent = 0;
		while (sent < 150) begin
			if ($urandom_range(0, 19) == 0) begin
				send_restore_image();
				sent += BACKUP_BYTES;
			end else begin
				send_random_beat();
				sent++;
			end
		end
	endtask

	task automatic test_backpressure();
		hold_request = 1'b1;
		for (int i = 0; i < 24; i++)
			if (i % 6 == 0)
				send_request(noisy_beat(REQ_SAVE));
			else
				send_random_beat();
	endtask

	task automatic test_back_to_back();
		quiet = 1'b1;
		for (int i = 0; i < 30; i++)
			send_random_beat();
		quiet = 1'b0;
	endtask

	initial begin
		level_hist = LEVELS_IDLE;
		for (int n = 0; n < NUM_SLOTS; n++)
			pulse_cnt[n] = '0;
		dirty = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_random_traffic();
		wait_drained();
		test_backpressure();
		wait_drained();
		test_back_to_back();
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("[quad_pulse_counter_with_backup_unit] OK");
		else
			$display("[quad_pulse_counter_with_backup_unit] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
sv/qpc_pkg.sv
sv/qpc_ctrl.sv
sv/qpc_datapath.sv
sv/quad_pulse_counter_with_backup_unit.sv
sim/testbench.sv
